/* design/tpr_pkg.sv */
package tpr_pkg;

   localparam int CFG_COUNT  = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int TEMP_W      = 15;
   localparam int ERR_W       = TEMP_W + 1;
   localparam int AVG_W       = TEMP_W + 1;
   localparam int DERIV_W     = AVG_W + 1;
   localparam int INTEG_W     = 24;
   localparam int GAIN_W      = 16;
   localparam int RATE_W      = 16;
   localparam int LIMIT_W     = 14;
   localparam int MUL_A_W     = INTEG_W;
   localparam int MUL_B_W     = GAIN_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int DRIVE_W     = 8;
   localparam int STATUS_W    = 2;
   localparam int ROUND_SHIFT = 12;

   localparam int DELAY_DEPTH      = 16;
   localparam int HEAD_W           = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int DRIVE_RESOLUTION = 255;
   localparam int INTEGRAL_HIGH    = 65536;
   localparam int INTEGRAL_LOW     = -65536;
   localparam int DERIV_HIGH       = 1024;
   localparam int DERIV_LOW        = -1024;

   localparam logic REQ_RESET = 1'b1;

   typedef enum logic [2:0] {
      CFG_GAIN_P          = 3'd0,
      CFG_GAIN_I          = 3'd1,
      CFG_GAIN_D          = 3'd2,
      CFG_MAX_CHANGE_RATE = 3'd3,
      CFG_MAX_OVERHEAT    = 3'd4,
      CFG_MAX_TEMPERATURE = 3'd5,
      CFG_SHUTOFF_MARGIN  = 3'd6,
      CFG_INTEGRATOR_BAND = 3'd7
   } cfg_idx_type;

   typedef struct packed {
      logic        [GAIN_W-1:0]  gain_p;
      logic        [GAIN_W-1:0]  gain_i;
      logic        [GAIN_W-1:0]  gain_d;
      logic        [RATE_W-1:0]  max_change_rate;
      logic        [LIMIT_W-1:0] max_overheat;
      logic signed [TEMP_W-1:0]  max_temperature;
      logic        [LIMIT_W-1:0] shutoff_margin;
      logic        [LIMIT_W-1:0] integrator_band;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_p:          GAIN_W'(256),
      gain_i:          GAIN_W'(4),
      gain_d:          GAIN_W'(512),
      max_change_rate: RATE_W'(320),
      max_overheat:    LIMIT_W'(160),
      max_temperature: TEMP_W'(4000),
      shutoff_margin:  LIMIT_W'(80),
      integrator_band: LIMIT_W'(80)
   };

   typedef enum logic [STATUS_W-1:0] {
      STS_REGULATE   = 2'd0,
      STS_FAULT      = 2'd1,
      STS_SHUTOFF    = 2'd2,
      STS_RESET_DONE = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      MUL_P,
      MUL_I,
      MUL_D
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DERIV,
      ST_DECIDE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic           load;
      logic           read_ring;
      logic           calc_deriv;
      logic           refill;
      logic           advance;
      logic           regulate;
      mul_sel_type    mul_sel;
      acc_op_type     acc_op;
      logic           set_result;
      logic           use_acc;
      rsp_status_type result_code;
      logic           push;
   } dp_cmd_type;

   typedef struct packed {
      logic is_reset;
      logic fault;
      logic shutoff;
      logic slot_free;
   } dp_sts_type;

endpackage

/* design/tpr_req_if.sv */
interface tpr_req_if import tpr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic signed [TEMP_W-1:0] temperature;
   logic signed [TEMP_W-1:0] target;

   modport source (output valid, req_type, temperature, target, input ready);
   modport sink   (input valid, req_type, temperature, target, output ready);
endinterface

/* design/tpr_rsp_if.sv */
interface tpr_rsp_if import tpr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DRIVE_W-1:0]  drive;
   logic [STATUS_W-1:0] status;

   modport source (output valid, drive, status, input ready);
   modport sink   (input valid, drive, status, output ready);
endinterface

/* design/tpr_ram.sv */
module tpr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/tpr_csr.sv */
module tpr_csr import tpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   cfg_idx_type idx;
   logic        wr_en;

   assign idx    = cfg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            CFG_GAIN_P:          cfg_in.gain_p          = pwdata[GAIN_W-1:0];
            CFG_GAIN_I:          cfg_in.gain_i          = pwdata[GAIN_W-1:0];
            CFG_GAIN_D:          cfg_in.gain_d          = pwdata[GAIN_W-1:0];
            CFG_MAX_CHANGE_RATE: cfg_in.max_change_rate = pwdata[RATE_W-1:0];
            CFG_MAX_OVERHEAT:    cfg_in.max_overheat    = pwdata[LIMIT_W-1:0];
            CFG_MAX_TEMPERATURE: cfg_in.max_temperature = $signed(pwdata[TEMP_W-1:0]);
            CFG_SHUTOFF_MARGIN:  cfg_in.shutoff_margin  = pwdata[LIMIT_W-1:0];
            CFG_INTEGRATOR_BAND: cfg_in.integrator_band = pwdata[LIMIT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CFG_GAIN_P:          prdata = CSR_DATA_W'(cfg_ff.gain_p);
         CFG_GAIN_I:          prdata = CSR_DATA_W'(cfg_ff.gain_i);
         CFG_GAIN_D:          prdata = CSR_DATA_W'(cfg_ff.gain_d);
         CFG_MAX_CHANGE_RATE: prdata = CSR_DATA_W'(cfg_ff.max_change_rate);
         CFG_MAX_OVERHEAT:    prdata = CSR_DATA_W'(cfg_ff.max_overheat);
         CFG_MAX_TEMPERATURE: prdata = {{(CSR_DATA_W-TEMP_W){1'b0}}, cfg_ff.max_temperature};
         CFG_SHUTOFF_MARGIN:  prdata = CSR_DATA_W'(cfg_ff.shutoff_margin);
         CFG_INTEGRATOR_BAND: prdata = CSR_DATA_W'(cfg_ff.integrator_band);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/tpr_ctrl.sv */
module tpr_ctrl import tpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.is_reset) begin
               cmd.refill      = 1'b1;
               cmd.set_result  = 1'b1;
               cmd.result_code = STS_RESET_DONE;
               state_in        = ST_DONE;
            end else begin
               cmd.read_ring = 1'b1;
               state_in      = ST_DERIV;
            end
         end
         ST_DERIV: begin
            cmd.calc_deriv = 1'b1;
            state_in       = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (sts.fault) begin
               cmd.advance     = 1'b1;
               cmd.set_result  = 1'b1;
               cmd.result_code = STS_FAULT;
               state_in        = ST_DONE;
            end else if (sts.shutoff) begin
               cmd.refill      = 1'b1;
               cmd.set_result  = 1'b1;
               cmd.result_code = STS_SHUTOFF;
               state_in        = ST_DONE;
            end else begin
               cmd.advance  = 1'b1;
               cmd.regulate = 1'b1;
               state_in     = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.mul_sel = MUL_P;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_sel = MUL_I;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_sel = MUL_D;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.set_result  = 1'b1;
            cmd.use_acc     = 1'b1;
            cmd.result_code = STS_REGULATE;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (sts.slot_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* design/tpr_datapath.sv */
module tpr_datapath import tpr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  dp_cmd_type               cmd,
   output dp_sts_type               sts,
   input  logic                     req_type,
   input  logic signed [TEMP_W-1:0] temperature,
   input  logic signed [TEMP_W-1:0] target,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [DRIVE_W-1:0]       drive,
   output logic [STATUS_W-1:0]      status
);

   localparam logic signed [DERIV_W-1:0] D_HI = DERIV_W'(DERIV_HIGH);
   localparam logic signed [DERIV_W-1:0] D_LO = DERIV_W'(DERIV_LOW);
   localparam logic signed [INTEG_W:0]   I_HI = (INTEG_W+1)'(INTEGRAL_HIGH);
   localparam logic signed [INTEG_W:0]   I_LO = (INTEG_W+1)'(INTEGRAL_LOW);
   localparam logic signed [SUM_W-1:0]   RND  = SUM_W'(1) <<< (ROUND_SHIFT - 1);
   localparam logic signed [SUM_W-1:0]   RES  = SUM_W'(DRIVE_RESOLUTION);

   logic                      req_type_ff;
   logic signed [TEMP_W-1:0]  temp_ff;
   logic signed [TEMP_W-1:0]  tgt_ff;
   logic signed [TEMP_W-1:0]  prev_ff;
   logic signed [TEMP_W-1:0]  prev_in;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [AVG_W-1:0]   avg_ff;
   logic signed [AVG_W-1:0]   fill_ff;
   logic signed [AVG_W-1:0]   fill_in;
   logic [DELAY_DEPTH-1:0]    vld_ff;
   logic [DELAY_DEPTH-1:0]    vld_in;
   logic                      rd_vld_ff;
   logic [HEAD_W-1:0]         head_ff;
   logic [HEAD_W-1:0]         head_in;
   logic signed [DERIV_W-1:0] deriv_ff;
   logic signed [DERIV_W-1:0] deriv_in;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [SUM_W-1:0]   acc_ff;
   logic [DRIVE_W-1:0]        res_drive_ff;
   rsp_status_type            res_code_ff;
   logic [DRIVE_W-1:0]        out_drive_ff;
   rsp_status_type            out_code_ff;
   logic                      out_vld_ff;

   logic [AVG_W-1:0]          ring_rd;
   logic signed [AVG_W-1:0]   ring_val;
   logic signed [ERR_W-1:0]   err_calc;
   logic signed [AVG_W-1:0]   avg_calc;
   logic signed [DERIV_W-1:0] deriv_calc;
   logic signed [DERIV_W-1:0] deriv_clamped;
   logic [DERIV_W-1:0]        deriv_mag;
   logic [ERR_W-1:0]          err_mag;
   logic signed [ERR_W:0]     overheat_sum;
   logic signed [ERR_W:0]     shutoff_sum;
   logic                      in_band;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_clamped;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [SUM_W-1:0]   acc_rnd;
   logic signed [SUM_W-1:0]   acc_shift;
   logic [DRIVE_W-1:0]        drive_calc;

   tpr_ram #(
      .WIDTH (AVG_W),
      .DEPTH (DELAY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.advance),
      .wr_addr (head_ff),
      .wr_data (avg_ff),
      .rd_en   (cmd.read_ring),
      .rd_addr (head_ff),
      .rd_data (ring_rd)
   );

   assign err_calc   = ERR_W'(tgt_ff) - ERR_W'(temp_ff);
   assign avg_calc   = AVG_W'(temp_ff) + AVG_W'(prev_ff);
   assign ring_val   = rd_vld_ff ? $signed(ring_rd) : fill_ff;
   assign deriv_calc = DERIV_W'(ring_val) - DERIV_W'(avg_ff);

   assign deriv_mag    = deriv_ff[DERIV_W-1] ? DERIV_W'(-deriv_ff) : DERIV_W'(deriv_ff);
   assign err_mag      = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign overheat_sum = (ERR_W+1)'(err_ff) + $signed({1'b0, (ERR_W)'(cfg.max_overheat)});
   assign shutoff_sum  = (ERR_W+1)'(err_ff) + $signed({1'b0, (ERR_W)'(cfg.shutoff_margin)});
   assign in_band      = err_mag < ERR_W'(cfg.integrator_band);

   assign sts.is_reset  = (req_type_ff == REQ_RESET);
   assign sts.fault     = (deriv_mag > DERIV_W'(cfg.max_change_rate)) ||
                          overheat_sum[ERR_W] ||
                          (temp_ff > cfg.max_temperature);
   assign sts.shutoff   = shutoff_sum[ERR_W];
   assign sts.slot_free = !out_vld_ff || rsp_ready;

   always_comb begin
      if (deriv_ff > D_HI) begin
         deriv_clamped = D_HI;
      end else if (deriv_ff < D_LO) begin
         deriv_clamped = D_LO;
      end else begin
         deriv_clamped = deriv_ff;
      end
   end

   assign integ_sum = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'(err_ff);

   always_comb begin
      if (integ_sum > I_HI) begin
         integ_clamped = INTEG_W'(I_HI);
      end else if (integ_sum < I_LO) begin
         integ_clamped = INTEG_W'(I_LO);
      end else begin
         integ_clamped = INTEG_W'(integ_sum);
      end
   end

   always_comb begin
      deriv_in = deriv_ff;
      if (cmd.calc_deriv) begin
         deriv_in = deriv_calc;
      end else if (cmd.regulate) begin
         deriv_in = deriv_clamped;
      end
   end

   always_comb begin
      integ_in = integ_ff;
      prev_in  = prev_ff;
      fill_in  = fill_ff;
      vld_in   = vld_ff;
      head_in  = head_ff;
      if (cmd.refill) begin
         integ_in = '0;
         prev_in  = temp_ff;
         fill_in  = AVG_W'({temp_ff, 1'b0});
         vld_in   = '0;
         head_in  = '0;
      end else if (cmd.advance) begin
         prev_in         = temp_ff;
         vld_in[head_ff] = 1'b1;
         head_in         = (head_ff == HEAD_W'(DELAY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         if (cmd.regulate && in_band) begin
            integ_in = integ_clamped;
         end
      end
   end

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_P:   mul_a = MUL_A_W'(err_ff);
         MUL_I:   mul_a = integ_ff;
         MUL_D:   mul_a = MUL_A_W'(deriv_ff);
         default: mul_a = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_P:   mul_b = $signed({1'b0, cfg.gain_p});
         MUL_I:   mul_b = $signed({1'b0, cfg.gain_i});
         MUL_D:   mul_b = $signed({1'b0, cfg.gain_d});
         default: mul_b = '0;
      endcase
   end

   assign acc_rnd   = acc_ff + RND;
   assign acc_shift = acc_rnd >>> ROUND_SHIFT;

   always_comb begin
      if (acc_ff[SUM_W-1]) begin
         drive_calc = '0;
      end else if (acc_shift > RES) begin
         drive_calc = DRIVE_W'(DRIVE_RESOLUTION);
      end else begin
         drive_calc = DRIVE_W'(acc_shift);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff <= req_type;
         temp_ff     <= temperature;
         tgt_ff      <= target;
      end
      if (cmd.read_ring) begin
         err_ff    <= err_calc;
         avg_ff    <= avg_calc;
         rd_vld_ff <= vld_ff[head_ff];
      end
      deriv_ff <= deriv_in;
      prod_ff  <= mul_a * mul_b;
      unique case (cmd.acc_op)
         ACC_LOAD: acc_ff <= SUM_W'(prod_ff);
         ACC_ADD:  acc_ff <= acc_ff + SUM_W'(prod_ff);
         default:  acc_ff <= acc_ff;
      endcase
      if (cmd.set_result) begin
         res_drive_ff <= cmd.use_acc ? drive_calc : '0;
         res_code_ff  <= cmd.result_code;
      end
      if (cmd.push) begin
         out_drive_ff <= res_drive_ff;
         out_code_ff  <= res_code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff   <= '0;
         prev_ff    <= '0;
         fill_ff    <= '0;
         vld_ff     <= '0;
         head_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         integ_ff <= integ_in;
         prev_ff  <= prev_in;
         fill_ff  <= fill_in;
         vld_ff   <= vld_in;
         head_ff  <= head_in;
         if (cmd.push) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_vld_ff;
   assign drive     = out_drive_ff;
   assign status    = out_code_ff;

endmodule

/* design/thermal_pid_regulator.sv */
// Temperature PID regulator. Each req transaction is one sample: a regulate request
// (req_type 0) returns a drive level from the PID sum of the error, a band-gated clamped
// integral and a derivative taken over a 16-deep ring of two-sample averages; a reset
// request (req_type 1) reloads the ring and previous sample from the given temperature
// and clears the integral. Exactly one rsp transaction follows each request. One request
// is worked at a time: the next one is accepted only after the last one's response has
// gone into the rsp register, which waits while that register stays full; a regulate
// request's three gain products go through one shared 24x17 multiplier in turn. Ring
// entries carry valid bits and read back the reload value until rewritten. Registers sit
// on the APB port at byte offsets 4*i and are to be written only while no request is
// in flight; the user is bound by this, and the block itself does not enforce it.
module thermal_pid_regulator import tpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tpr_req_if.sink               req_chan,
   tpr_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;

   tpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tpr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .sts         (sts),
      .req_type    (req_chan.req_type),
      .temperature (req_chan.temperature),
      .target      (req_chan.target),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .drive       (rsp_chan.drive),
      .status      (rsp_chan.status)
   );

endmodule

/* design/tpr_checker.sv */
module tpr_checker import tpr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [DRIVE_W-1:0]  drive,
   input logic [STATUS_W-1:0] status
);

   a_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != STS_REGULATE) |-> drive == '0)
      else $error("nonzero drive on fault, shutoff or reset response");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(req_valid && req_ready))
      else $error("request accepted while previous one in progress");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("response appeared too soon after request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(drive) && $stable(status))
      else $error("stalled response changed");

endmodule

bind thermal_pid_regulator tpr_checker u_tpr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .drive     (rsp_chan.drive),
   .status    (rsp_chan.status)
);
